// File: sv/dsw_pkg.sv
// dice sum way counter: shared types and constants
// no dependencies; imported by dsw_ctrl and dice_sum_way_counter
package dsw_pkg;

    localparam int QUERY_W     = 8;
    localparam int COUNT_W     = 32;
    localparam int DICE_W      = 4;
    localparam int SIDES_W     = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_DICE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDES = 1'd1;

    typedef struct packed {
        logic wr_en;
        logic wr_sel;
        logic last;
        logic use_a;
        logic use_b;
        logic seed;
        logic data_sel;
        logic resp_mem;
        logic resp_zero;
        logic low;
    } t_seq_ctl;

endpackage

// File: sv/dsw_ram.sv
// generic synchronous ram: one write port, two registered read ports
// no dependencies
module dsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 129
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// File: sv/dsw_ctrl.sv
// dice sum way counter sequencer: config registers, table build and query control
// depends on dsw_pkg
module dsw_ctrl #(
    parameter int MAX_DICE  = 8,
    parameter int MAX_SIDES = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         start,
    input  logic [dsw_pkg::QUERY_W-1:0]                  i_query_sum,
    input  logic                                         i_cfg_wr_en,
    input  logic [dsw_pkg::CFG_INDEX_W-1:0]              i_cfg_index,
    input  logic [dsw_pkg::CFG_DATA_W-1:0]               i_cfg_data,
    output logic                                         o_busy,
    output logic [$clog2(MAX_DICE*MAX_SIDES+1)-1:0]      o_addr_a,
    output logic [$clog2(MAX_DICE*MAX_SIDES+1)-1:0]      o_addr_b,
    output logic [$clog2(MAX_DICE*MAX_SIDES+1)-1:0]      o_wr_addr,
    output dsw_pkg::t_seq_ctl                            o_ctl
);
    import dsw_pkg::*;

    localparam int ROW_LEN = MAX_DICE * MAX_SIDES + 1;
    localparam int AW      = $clog2(ROW_LEN);
    localparam int IW      = AW + 1;
    localparam int CW      = (IW > QUERY_W) ? IW : QUERY_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROW   = 3'd1;
    localparam logic [2:0] S_GAP   = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_QUERY = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [DICE_W-1:0]  r_dice;
    logic [SIDES_W-1:0] r_sides;
    logic               r_ready, n_ready;
    logic [AW-1:0]      r_query, n_query;
    logic               r_low, n_low;
    logic [IW-1:0]      r_row, n_row;
    logic [IW-1:0]      r_j, n_j;
    logic [IW-1:0]      r_prev_top, n_prev_top;
    logic [IW-1:0]      r_row_top, n_row_top;
    logic [IW-1:0]      r_base, n_base;

    logic               r_ws_en, n_ws_en;
    logic [AW-1:0]      r_ws_addr, n_ws_addr;
    logic               r_ws_sel, n_ws_sel;
    logic               r_ws_last, n_ws_last;
    logic               r_use_a, n_use_a;
    logic               r_use_b, n_use_b;
    logic               r_seed, n_seed;
    logic               r_data_sel, n_data_sel;

    logic [CW-1:0]      w_dice_c, w_sides_c, w_d, w_s, w_top, w_q;
    logic [IW-1:0]      w_d_i, w_s_i;
    logic               w_bad, w_accept;
    logic [IW-1:0]      w_jm1, w_mirror, w_row_lo;
    logic [AW-1:0]      w_qaddr;

    // saturated config and range test
    assign w_dice_c  = CW'(r_dice);
    assign w_sides_c = CW'(r_sides);
    assign w_d       = (w_dice_c > CW'(MAX_DICE)) ? CW'(MAX_DICE) : w_dice_c;
    assign w_s       = (w_sides_c > CW'(MAX_SIDES)) ? CW'(MAX_SIDES) : w_sides_c;
    assign w_top     = CW'(w_d * w_s);
    assign w_q       = CW'(i_query_sum);
    assign w_d_i     = w_d[IW-1:0];
    assign w_s_i     = w_s[IW-1:0];
    assign w_bad     = (w_d == '0) || (w_s == '0) || (w_q > w_top);
    assign w_accept  = start && (r_state == S_IDLE);

    // read addresses for the row being built and for the query
    assign w_jm1    = r_j - IW'(1);
    assign w_mirror = r_base - r_j;
    assign w_row_lo = r_row - IW'(1);
    assign w_qaddr  = (r_state == S_IDLE) ? w_q[AW-1:0] : r_query;

    assign o_addr_a  = (r_state == S_ROW) ? w_jm1[AW-1:0] : w_qaddr;
    assign o_addr_b  = w_mirror[AW-1:0];
    assign o_wr_addr = r_ws_addr;
    assign o_busy    = (r_state != S_IDLE);

    always_comb begin
        o_ctl.wr_en     = r_ws_en;
        o_ctl.wr_sel    = r_ws_sel;
        o_ctl.last      = r_ws_last;
        o_ctl.use_a     = r_use_a;
        o_ctl.use_b     = r_use_b;
        o_ctl.seed      = r_seed;
        o_ctl.data_sel  = (r_state == S_QUERY) ? w_d[0] : r_data_sel;
        o_ctl.resp_mem  = (r_state == S_QUERY);
        o_ctl.resp_zero = w_accept && w_bad;
        o_ctl.low       = r_low;
    end

    always_comb begin
        n_state    = r_state;
        n_ready    = r_ready;
        n_query    = r_query;
        n_low      = r_low;
        n_row      = r_row;
        n_j        = r_j;
        n_prev_top = r_prev_top;
        n_row_top  = r_row_top;
        n_base     = r_base;
        n_ws_en    = 1'b0;
        n_ws_addr  = r_ws_addr;
        n_ws_sel   = r_ws_sel;
        n_ws_last  = 1'b0;
        n_use_a    = r_use_a;
        n_use_b    = r_use_b;
        n_seed     = r_seed;
        n_data_sel = r_data_sel;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !w_bad) begin
                    n_query = w_q[AW-1:0];
                    n_low   = (w_q < w_d);
                    if (r_ready) begin
                        n_state = S_QUERY;
                    end else begin
                        n_row      = IW'(1);
                        n_j        = IW'(1);
                        n_prev_top = '0;
                        n_row_top  = w_s_i;
                        n_base     = w_s_i + IW'(1);
                        n_state    = S_ROW;
                    end
                end
            end
            S_ROW: begin
                n_ws_en    = 1'b1;
                n_ws_addr  = r_j[AW-1:0];
                n_ws_sel   = r_row[0];
                n_ws_last  = (r_j == r_row_top);
                n_use_a    = (w_jm1 >= w_row_lo) && (w_jm1 <= r_prev_top);
                n_use_b    = (w_mirror >= w_row_lo) && (w_mirror <= r_prev_top);
                n_seed     = (r_row == IW'(1));
                n_data_sel = ~r_row[0];
                n_j        = r_j + IW'(1);
                if (r_j == r_row_top) begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                if (r_row == w_d_i) begin
                    n_ready = 1'b1;
                    n_state = S_FETCH;
                end else begin
                    n_row      = r_row + IW'(1);
                    n_j        = r_row + IW'(1);
                    n_prev_top = r_row_top;
                    n_row_top  = r_row_top + w_s_i;
                    n_base     = r_base + w_s_i + IW'(1);
                    n_state    = S_ROW;
                end
            end
            S_FETCH: begin
                n_state = S_QUERY;
            end
            S_QUERY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_wr_en) begin
            n_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ready   <= 1'b0;
            r_dice    <= DICE_W'(1);
            r_sides   <= SIDES_W'(6);
            r_ws_en   <= 1'b0;
            r_ws_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_ws_en   <= n_ws_en;
            r_ws_last <= n_ws_last;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_DICE:  r_dice  <= i_cfg_data[DICE_W-1:0];
                    CFG_SIDES: r_sides <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_query    <= n_query;
        r_low      <= n_low;
        r_row      <= n_row;
        r_j        <= n_j;
        r_prev_top <= n_prev_top;
        r_row_top  <= n_row_top;
        r_base     <= n_base;
        r_ws_addr  <= n_ws_addr;
        r_ws_sel   <= n_ws_sel;
        r_use_a    <= n_use_a;
        r_use_b    <= n_use_b;
        r_seed     <= n_seed;
        r_data_sel <= n_data_sel;
    end

endmodule

// File: sv/dice_sum_way_counter.sv
// dice sum way counter top level: row memories, accumulate datapath, result registers
// depends on dsw_pkg, dsw_ram and dsw_ctrl
//
// Counts the throws of the configured dice whose faces total the queried sum.
// After reset or any configuration write the first in-range query builds the
// count table row by row in two ping-pong memories. Row i holds
// i*(sides-1)+1 entries, written one per cycle, and each row is followed by an
// idle gap state. A fetch state and a read state come after the last row, while
// busy stays high, and the result follows in the next cycle. After that every
// in-range query holds busy only for the memory read of the final row, and its
// result comes in the cycle after that; a new transfer can follow once busy
// drops. A query that is out of range, or any query with zero dice or sides,
// returns zero with sum_in_range low in the cycle after the transfer and leaves
// busy low.
// o_valid marks each result for exactly one cycle; results cannot be held off.
module dice_sum_way_counter #(
    parameter int MAX_DICE  = 8,
    parameter int MAX_SIDES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dsw_pkg::QUERY_W-1:0]     i_query_sum,
    output logic                            o_valid,
    output logic [dsw_pkg::COUNT_W-1:0]     o_way_count,
    output logic                            o_sum_in_range,
    input  logic                            i_cfg_wr_en,
    input  logic [dsw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dsw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dsw_pkg::*;

    localparam int ROW_LEN = MAX_DICE * MAX_SIDES + 1;
    localparam int AW      = $clog2(ROW_LEN);

    t_seq_ctl           w_ctl;
    logic [AW-1:0]      w_addr_a, w_addr_b, w_wr_addr;
    logic [COUNT_W-1:0] w_rd_a0, w_rd_b0, w_rd_a1, w_rd_b1;
    logic [COUNT_W-1:0] w_rd_a, w_rd_b, w_term_a, w_term_b, w_sum;
    logic [COUNT_W-1:0] r_acc;
    logic               r_valid;
    logic [COUNT_W-1:0] r_way;
    logic               r_in_range;

    dsw_ctrl #(
        .MAX_DICE  (MAX_DICE),
        .MAX_SIDES (MAX_SIDES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_query_sum (i_query_sum),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_addr_a    (w_addr_a),
        .o_addr_b    (w_addr_b),
        .o_wr_addr   (w_wr_addr),
        .o_ctl       (w_ctl)
    );

    dsw_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (ROW_LEN)
    ) u_ram0 (
        .i_clk       (i_clk),
        .i_wr_en     (w_ctl.wr_en && !w_ctl.wr_sel),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_sum),
        .i_rd_addr_a (w_addr_a),
        .i_rd_addr_b (w_addr_b),
        .o_rd_data_a (w_rd_a0),
        .o_rd_data_b (w_rd_b0)
    );

    dsw_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (ROW_LEN)
    ) u_ram1 (
        .i_clk       (i_clk),
        .i_wr_en     (w_ctl.wr_en && w_ctl.wr_sel),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_sum),
        .i_rd_addr_a (w_addr_a),
        .i_rd_addr_b (w_addr_b),
        .o_rd_data_a (w_rd_a1),
        .o_rd_data_b (w_rd_b1)
    );

    assign w_rd_a = w_ctl.data_sel ? w_rd_a1 : w_rd_a0;
    assign w_rd_b = w_ctl.data_sel ? w_rd_b1 : w_rd_b0;

    // entries outside the previous row read as zero, the seed row is a single one
    assign w_term_a = !w_ctl.use_a ? '0 : (w_ctl.seed ? COUNT_W'(1) : w_rd_a);
    assign w_term_b = !w_ctl.use_b ? '0 : (w_ctl.seed ? COUNT_W'(1) : w_rd_b);
    assign w_sum    = r_acc + w_term_a - w_term_b;

    always_ff @(posedge i_clk) begin
        r_acc <= (w_ctl.wr_en && !w_ctl.last) ? w_sum : '0;
        r_way <= (w_ctl.resp_mem && !w_ctl.low) ? w_rd_a : '0;
        r_in_range <= w_ctl.resp_mem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl.resp_mem || w_ctl.resp_zero;
        end
    end

    assign o_valid        = r_valid;
    assign o_way_count    = r_way;
    assign o_sum_in_range = r_in_range;

`ifndef SYNTH
    a_zero_when_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sum_in_range |-> o_way_count == '0)
        else $error("out-of-range result carries a nonzero count");

    a_no_write_to_read_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.wr_en |-> w_ctl.wr_sel != w_ctl.data_sel)
        else $error("row build writes the memory it reads");

    a_transfer_progresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted query neither busy nor answered");
`endif

endmodule

// File: test/dice_sum_way_counter_tb.sv
// self-checking testbench for dice_sum_way_counter: directed and random queries
// across many dice/side settings, checked against a way-count table built here
// depends on dsw_pkg and the dice_sum_way_counter rtl
module dice_sum_way_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsw_pkg::*;

    localparam int MAX_DICE    = 8;
    localparam int MAX_SIDES   = 16;
    localparam int SUM_LAST    = MAX_DICE * MAX_SIDES;
    localparam int RANDOM_ITEMS = 1550;
    localparam int SETTLE      = 20;
    localparam int STALL_LIMIT = 4000;

    class way_count_board;
        logic [DICE_W-1:0]  dice_reg;
        logic [SIDES_W-1:0] sides_reg;
        logic [COUNT_W-1:0] ways_by_sum [0:SUM_LAST];
        logic [COUNT_W-1:0] exp_count [$];
        logic               exp_in_range [$];
        int                 errors;

        function new();
            dice_reg  = 4'd1;
            sides_reg = 5'd6;
            errors    = 0;
            rebuild();
        endfunction

        function int dice_used();
            return (dice_reg > MAX_DICE) ? MAX_DICE : int'(dice_reg);
        endfunction

        function int sides_used();
            return (sides_reg > MAX_SIDES) ? MAX_SIDES : int'(sides_reg);
        endfunction

        function int top_sum();
            return dice_used() * sides_used();
        endfunction

        // plain convolution, one die at a time
        function void rebuild();
            longint unsigned prev [0:SUM_LAST];
            longint unsigned cur [0:SUM_LAST];
            longint unsigned acc;
            int d;
            int s;
            d = dice_used();
            s = sides_used();
            for (int j = 0; j <= SUM_LAST; j++) cur[j] = 0;
            cur[0] = 1;
            for (int n = 1; n <= d; n++) begin
                prev = cur;
                for (int j = 0; j <= SUM_LAST; j++) begin
                    acc = 0;
                    for (int k = 1; k <= s; k++) begin
                        if (j - k >= 0) acc += prev[j-k];
                    end
                    cur[j] = acc;
                end
            end
            for (int j = 0; j <= SUM_LAST; j++) ways_by_sum[j] = cur[j][COUNT_W-1:0];
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DICE) begin
                dice_reg = data[DICE_W-1:0];
            end else if (idx == CFG_SIDES) begin
                sides_reg = data[SIDES_W-1:0];
            end
            rebuild();
        endfunction

        function void note_query(logic [QUERY_W-1:0] q);
            int top;
            top = top_sum();
            if (top == 0 || int'(q) > top) begin
                exp_count.push_back('0);
                exp_in_range.push_back(1'b0);
            end else begin
                exp_count.push_back(ways_by_sum[q]);
                exp_in_range.push_back(1'b1);
            end
        endfunction

        function int pending();
            return exp_count.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("%0t: %s", $time, msg);
        endtask

        task check_result(logic [COUNT_W-1:0] count, logic in_range);
            logic [COUNT_W-1:0] want_count;
            logic               want_in_range;
            if (exp_count.size() == 0) begin
                report($sformatf("unexpected result way_count=%0d sum_in_range=%0b",
                                 count, in_range));
            end else begin
                want_count    = exp_count.pop_front();
                want_in_range = exp_in_range.pop_front();
                if (count !== want_count)
                    report($sformatf("way_count got %0d want %0d", count, want_count));
                if (in_range !== want_in_range)
                    report($sformatf("sum_in_range got %0b want %0b", in_range, want_in_range));
            end
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [QUERY_W-1:0]     i_query_sum;
    logic                   o_valid;
    logic [COUNT_W-1:0]     o_way_count;
    logic                   o_sum_in_range;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    way_count_board board;
    int n_accepted;
    int n_sent;
    int idle_cycles;

    dice_sum_way_counter #(
        .MAX_DICE  (MAX_DICE),
        .MAX_SIDES (MAX_SIDES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_query_sum    (i_query_sum),
        .o_valid        (o_valid),
        .o_way_count    (o_way_count),
        .o_sum_in_range (o_sum_in_range),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) board.check_result(o_way_count, o_sum_in_range);
            if (start && !busy) begin
                board.note_query(i_query_sum);
                n_accepted++;
            end
            if (o_valid || (start && !busy)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("dice_sum_way_counter_tb NOT OK");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task send_query(logic [QUERY_W-1:0] q, int gap);
        int prior;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       = 1'b1;
        i_query_sum = q;
        prior       = n_accepted;
        do @(negedge i_clk); while (n_accepted == prior);
        n_sent++;
    endtask

    task wait_idle();
        start = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        board.write_reg(idx, data);
    endtask

    task directed_setting(logic [CFG_DATA_W-1:0] dice_data, logic [CFG_DATA_W-1:0] sides_data,
                          bit do_write);
        int top;
        wait_idle();
        if (do_write) begin
            write_reg(CFG_DICE, dice_data);
            write_reg(CFG_SIDES, sides_data);
        end
        top = board.top_sum();
        send_query(8'd0, 0);
        send_query(QUERY_W'(top), $urandom_range(0, 3));
        send_query(QUERY_W'(top + 1), 0);
        send_query(8'hff, $urandom_range(0, 3));
    endtask

    function logic [CFG_DATA_W-1:0] pick_dice_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return {1'($urandom_range(0, 1)), 4'd0};
        if (r == 1) return {1'($urandom_range(0, 1)), 4'($urandom_range(MAX_DICE + 1, 15))};
        return {1'($urandom_range(0, 1)), 4'($urandom_range(1, MAX_DICE))};
    endfunction

    function logic [CFG_DATA_W-1:0] pick_sides_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 5'd0;
        if (r == 1) return 5'($urandom_range(MAX_SIDES + 1, 31));
        return 5'($urandom_range(1, MAX_SIDES));
    endfunction

    initial begin
        int phase_items;
        int top;
        bit no_gaps;
        logic [QUERY_W-1:0] q;

        board       = new();
        n_accepted  = 0;
        n_sent      = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_query_sum = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_DICE;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_setting(5'd0, 5'd0, 1'b0);
        directed_setting(5'd8, 5'd16, 1'b1);
        directed_setting(5'd1, 5'd1, 1'b1);
        directed_setting(5'd0, 5'd6, 1'b1);
        directed_setting(5'd5, 5'd0, 1'b1);
        directed_setting(5'd31, 5'd31, 1'b1);

        while (n_sent < RANDOM_ITEMS + 24) begin
            wait_idle();
            case ($urandom_range(0, 3))
                0: write_reg(CFG_DICE, pick_dice_data());
                1: write_reg(CFG_SIDES, pick_sides_data());
                default: begin
                    write_reg(CFG_SIDES, pick_sides_data());
                    write_reg(CFG_DICE, pick_dice_data());
                end
            endcase
            top         = board.top_sum();
            phase_items = $urandom_range(20, 80);
            no_gaps     = ($urandom_range(0, 3) == 0);
            repeat (phase_items) begin
                if (top > 0 && $urandom_range(0, 99) < 85) begin
                    q = QUERY_W'($urandom_range(0, top));
                end else begin
                    q = QUERY_W'($urandom_range(0, 255));
                end
                send_query(q, no_gaps ? 0 : $urandom_range(0, 15));
            end
        end

        wait_idle();
        if (board.errors == 0) begin
            $display("dice_sum_way_counter_tb OK");
        end else begin
            $display("dice_sum_way_counter_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/dsw_pkg.sv
sv/dsw_ram.sv
sv/dsw_ctrl.sv
sv/dice_sum_way_counter.sv
test/dice_sum_way_counter_tb.sv
